@@ design/capw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capw_pkg
// Shared constants, widths and helpers for the clipped alpha pixel writer.
// ----------------------------------------------------------------------------
package capw_pkg;

    // Largest canvas side in pixels; the bounds test saturates canvas registers to this.
    localparam int CANVAS_MAX = 4096;

    localparam int POS_W    = 16;
    localparam int COLOR_W  = 32;
    localparam int CLIP_W   = 13;
    localparam int STRIDE_W = 14;
    localparam int ADDR_W   = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Signed compare width: one bit above the widest coordinate or bound.
    localparam int CMP_W = 17;
    // Bits of an in-canvas coordinate.
    localparam int IDX_W = $clog2(CANVAS_MAX);
    localparam int ADDR_SUM_W = IDX_W + STRIDE_W + 1;

    localparam logic [CMP_W-1:0] CANVAS_MAX_C = CMP_W'(CANVAS_MAX);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE    = 3'd6;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
    localparam logic [15:0] ROUND_HALF   = 16'd127;

    // Exact floor(t / 255) for t up to 255*255 + 127.
    function automatic logic [7:0] div255(input logic [15:0] t);
        logic [16:0] s;
        s = {1'b0, t} + 17'd1 + {9'd0, t[15:8]};
        return s[15:8];
    endfunction

endpackage
`default_nettype wire

@@ design/capw_blend.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capw_blend
// Two-stage source-over blend datapath; result is combinational off stage 2.
// ----------------------------------------------------------------------------
module capw_blend
(
    input  wire logic                         clk,
    input  wire logic                         advance,
    input  wire logic [capw_pkg::COLOR_W-1:0] src_in,
    input  wire logic [capw_pkg::COLOR_W-1:0] dst_in,
    output logic      [capw_pkg::COLOR_W-1:0] blend_out,
    output logic      [capw_pkg::COLOR_W-1:0] dst_out
);

    // stage 1: products
    logic [15:0] ps_reg [3];
    logic [15:0] pd_reg [3];
    logic [15:0] pa_reg;
    logic [capw_pkg::COLOR_W-1:0] src1_reg;
    logic [capw_pkg::COLOR_W-1:0] dst1_reg;

    logic [15:0] ps_next [3];
    logic [15:0] pd_next [3];
    logic [15:0] pa_next;
    logic [7:0]  alpha_in;
    logic [7:0]  inv_alpha;

    // stage 2: rounded sums
    logic [15:0] sum_reg [3];
    logic [15:0] suma_reg;
    logic [capw_pkg::COLOR_W-1:0] src2_reg;
    logic [capw_pkg::COLOR_W-1:0] dst2_reg;

    logic [15:0] sum_next [3];
    logic [15:0] suma_next;

    logic [7:0]  chan [3];
    logic [7:0]  alpha2;
    logic [8:0]  alpha_out;

    always_comb
    begin
        alpha_in  = src_in[31:24];
        inv_alpha = capw_pkg::ALPHA_OPAQUE - alpha_in;
        for (int c = 0; c < 3; c++)
        begin
            ps_next[c] = 16'(src_in[8*c +: 8]) * 16'(alpha_in);
            pd_next[c] = 16'(dst_in[8*c +: 8]) * 16'(inv_alpha);
        end
        pa_next = 16'(dst_in[31:24]) * 16'(inv_alpha);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ps_reg   <= ps_next;
            pd_reg   <= pd_next;
            pa_reg   <= pa_next;
            src1_reg <= src_in;
            dst1_reg <= dst_in;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum_next[c] = ps_reg[c] + pd_reg[c] + capw_pkg::ROUND_HALF;
        end
        suma_next = pa_reg + capw_pkg::ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg  <= sum_next;
            suma_reg <= suma_next;
            src2_reg <= src1_reg;
            dst2_reg <= dst1_reg;
        end
    end

    always_comb
    begin
        alpha2 = src2_reg[31:24];
        for (int c = 0; c < 3; c++)
        begin
            chan[c] = capw_pkg::div255(sum_reg[c]);
        end
        // never exceeds 255
        alpha_out = {1'b0, alpha2} + {1'b0, capw_pkg::div255(suma_reg)};
        if (alpha2 == capw_pkg::ALPHA_OPAQUE)
        begin
            blend_out = src2_reg;
        end
        else if (alpha2 == capw_pkg::ALPHA_CLEAR)
        begin
            blend_out = dst2_reg;
        end
        else
        begin
            blend_out = {alpha_out[7:0], chan[2], chan[1], chan[0]};
        end
    end

    assign dst_out = dst2_reg;

endmodule
`default_nettype wire

@@ design/clipped_alpha_pixel_write.sv @@
// Throughput: one word per cycle; the three stages (multiply, add, divide
//   by 255 and select) move together and hold as a whole while out_stall
//   keeps the output register full.
// Reset: rst_n clears the stage valid bits and loads the register defaults
//   (clip 0..4096 on both axes, canvas 4096 x 4096, stride 4096).
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_alpha_pixel_write
// Clip test, frame buffer address and source-over blend for ABGR8888 pixels.
// ----------------------------------------------------------------------------
module clipped_alpha_pixel_write
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // configuration write port
    input  wire logic                            cfg_write,
    input  wire logic [capw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [capw_pkg::CFG_DATA_W-1:0] cfg_data,

    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [capw_pkg::POS_W-1:0]      pos_x,
    input  wire logic [capw_pkg::POS_W-1:0]      pos_y,
    input  wire logic [capw_pkg::COLOR_W-1:0]    src_color,
    input  wire logic [capw_pkg::COLOR_W-1:0]    dest_color,

    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 write_enable,
    output logic      [capw_pkg::ADDR_W-1:0]     word_address,
    output logic      [capw_pkg::COLOR_W-1:0]    blended_color
);

    localparam int CMP_W    = capw_pkg::CMP_W;
    localparam int IDX_W    = capw_pkg::IDX_W;
    localparam int STRIDE_W = capw_pkg::STRIDE_W;
    localparam int CLIP_W   = capw_pkg::CLIP_W;
    localparam int PROD_W   = IDX_W + STRIDE_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CLIP_W-1:0]   clip_left_reg;
    logic [CLIP_W-1:0]   clip_top_reg;
    logic [CLIP_W-1:0]   clip_right_reg;
    logic [CLIP_W-1:0]   clip_bottom_reg;
    logic [CLIP_W-1:0]   canvas_width_reg;
    logic [CLIP_W-1:0]   canvas_height_reg;
    logic [STRIDE_W-1:0] row_stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg     <= '0;
            clip_top_reg      <= '0;
            clip_right_reg    <= CLIP_W'(4096);
            clip_bottom_reg   <= CLIP_W'(4096);
            canvas_width_reg  <= CLIP_W'(4096);
            canvas_height_reg <= CLIP_W'(4096);
            row_stride_reg    <= STRIDE_W'(4096);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                capw_pkg::REG_CLIP_LEFT:     clip_left_reg     <= cfg_data[CLIP_W-1:0];
                capw_pkg::REG_CLIP_TOP:      clip_top_reg      <= cfg_data[CLIP_W-1:0];
                capw_pkg::REG_CLIP_RIGHT:    clip_right_reg    <= cfg_data[CLIP_W-1:0];
                capw_pkg::REG_CLIP_BOTTOM:   clip_bottom_reg   <= cfg_data[CLIP_W-1:0];
                capw_pkg::REG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data[CLIP_W-1:0];
                capw_pkg::REG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data[CLIP_W-1:0];
                capw_pkg::REG_ROW_STRIDE:    row_stride_reg    <= cfg_data[STRIDE_W-1:0];
                default:                     ; // unused index: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves together. The whole pipe holds
    // only while the output register is full and stalled, so bubbles in
    // front of it cost nothing and no word is dropped or repeated.
    // ------------------------------------------------------------------
    logic advance;
    logic v1_reg;
    logic v2_reg;
    logic out_valid_reg;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: bounds test and row * stride multiply
    // ------------------------------------------------------------------
    logic signed [CMP_W-1:0] x_s;
    logic signed [CMP_W-1:0] y_s;
    logic [CMP_W-1:0] cw_full;
    logic [CMP_W-1:0] ch_full;
    logic [CMP_W-1:0] cw_sat;
    logic [CMP_W-1:0] ch_sat;
    logic             ok_next;
    logic [PROD_W-1:0] prod_next;

    logic              ok1_reg;
    logic [PROD_W-1:0] prod1_reg;
    logic [IDX_W-1:0]  x1_reg;

    always_comb
    begin
        x_s = CMP_W'(signed'(pos_x));
        y_s = CMP_W'(signed'(pos_y));
        cw_full = CMP_W'(canvas_width_reg);
        ch_full = CMP_W'(canvas_height_reg);
        // canvas register values are saturated to the largest supported canvas
        cw_sat = (cw_full > capw_pkg::CANVAS_MAX_C) ? capw_pkg::CANVAS_MAX_C : cw_full;
        ch_sat = (ch_full > capw_pkg::CANVAS_MAX_C) ? capw_pkg::CANVAS_MAX_C : ch_full;

        ok_next = (x_s >= signed'(CMP_W'(clip_left_reg)))   &&
                  (x_s <  signed'(CMP_W'(clip_right_reg)))  &&
                  (y_s >= signed'(CMP_W'(clip_top_reg)))    &&
                  (y_s <  signed'(CMP_W'(clip_bottom_reg))) &&
                  !pos_x[capw_pkg::POS_W-1] && (x_s < signed'(cw_sat)) &&
                  !pos_y[capw_pkg::POS_W-1] && (y_s < signed'(ch_sat));

        // an accepted row is below CANVAS_MAX, so its low bits are exact
        prod_next = PROD_W'(pos_y[IDX_W-1:0]) * PROD_W'(row_stride_reg);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ok1_reg   <= ok_next;
            prod1_reg <= prod_next;
            x1_reg    <= pos_x[IDX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: address add, zero for rejected pixels
    // ------------------------------------------------------------------
    logic [capw_pkg::ADDR_SUM_W-1:0] addr_sum;
    logic [capw_pkg::ADDR_W-1:0]     addr_next;
    logic                            ok2_reg;
    logic [capw_pkg::ADDR_W-1:0]     addr2_reg;

    always_comb
    begin
        addr_sum  = capw_pkg::ADDR_SUM_W'(prod1_reg) + capw_pkg::ADDR_SUM_W'(x1_reg);
        addr_next = ok1_reg ? capw_pkg::ADDR_W'(addr_sum) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ok2_reg   <= ok1_reg;
            addr2_reg <= addr_next;
        end
    end

    // ------------------------------------------------------------------
    // Blend datapath runs alongside stages 1 and 2
    // ------------------------------------------------------------------
    logic [capw_pkg::COLOR_W-1:0] blend_color;
    logic [capw_pkg::COLOR_W-1:0] dst2_color;

    capw_blend u_blend
    (
        .clk       (clk),
        .advance   (advance),
        .src_in    (src_color),
        .dst_in    (dest_color),
        .blend_out (blend_color),
        .dst_out   (dst2_color)
    );

    // ------------------------------------------------------------------
    // Stage 3: output register; rejected pixels pass the destination
    // ------------------------------------------------------------------
    logic                         we_reg;
    logic [capw_pkg::ADDR_W-1:0]  addr_reg;
    logic [capw_pkg::COLOR_W-1:0] color_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            we_reg    <= ok2_reg;
            addr_reg  <= addr2_reg;
            color_reg <= ok2_reg ? blend_color : dst2_color;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = we_reg;
    assign word_address  = addr_reg;
    assign blended_color = color_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_reject_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !we_reg |-> addr_reg == '0)
        else $error("rejected pixel carries a nonzero address");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted word did not enter stage 1");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && advance |=> v2_reg)
        else $error("word lost between stage 1 and stage 2");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(v1_reg) && $stable(v2_reg))
        else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire

@@ tb/clipped_alpha_pixel_write_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_alpha_pixel_write_test
// Self-checking bench for the clipped source-over pixel writer: directed
// corner pixels and random pixels under a series of clip, canvas and stride
// settings, with random idling and stalls on both channels, checked word by
// word against a behavioral predictor.
// ----------------------------------------------------------------------------
module clipped_alpha_pixel_write_test;

    // Cycles with no handshake on either side before the run is declared hung.
    // The longest legal quiet spell is the output hold-off below plus a
    // configuration phase, both far shorter.
    localparam int HANG_LIMIT   = 1000;
    // Output hold-off that backs up the pipeline into in_stall.
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AT_WORD = 150;
    // Pipeline depth plus margin; used after a drain and at the end.
    localparam int SETTLE       = 8;

    typedef struct packed {
        logic [capw_pkg::POS_W-1:0]   pos_x;
        logic [capw_pkg::POS_W-1:0]   pos_y;
        logic [capw_pkg::COLOR_W-1:0] src;
        logic [capw_pkg::COLOR_W-1:0] dest;
    } pixel_word_t;

    typedef struct packed {
        logic                         enable;
        logic [capw_pkg::ADDR_W-1:0]  address;
        logic [capw_pkg::COLOR_W-1:0] color;
    } pixel_write_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_write = 1'b0;
    logic [capw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [capw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                         in_valid   = 1'b0;
    logic                         in_stall;
    logic [capw_pkg::POS_W-1:0]   pos_x      = '0;
    logic [capw_pkg::POS_W-1:0]   pos_y      = '0;
    logic [capw_pkg::COLOR_W-1:0] src_color  = '0;
    logic [capw_pkg::COLOR_W-1:0] dest_color = '0;

    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         write_enable;
    logic [capw_pkg::ADDR_W-1:0]  word_address;
    logic [capw_pkg::COLOR_W-1:0] blended_color;

    // Register shadows, tracking every write made on the config port.
    logic [capw_pkg::CLIP_W-1:0]   clip_left_r   = 13'd0;
    logic [capw_pkg::CLIP_W-1:0]   clip_top_r    = 13'd0;
    logic [capw_pkg::CLIP_W-1:0]   clip_right_r  = 13'd4096;
    logic [capw_pkg::CLIP_W-1:0]   clip_bottom_r = 13'd4096;
    logic [capw_pkg::CLIP_W-1:0]   canvas_w_r    = 13'd4096;
    logic [capw_pkg::CLIP_W-1:0]   canvas_h_r    = 13'd4096;
    logic [capw_pkg::STRIDE_W-1:0] row_stride_r  = 14'd4096;

    pixel_word_t  pending_pixels[$];
    pixel_write_t expected_writes[$];
    pixel_word_t  offered;

    bit no_idling  = 1'b0;
    int fail_count = 0;
    int writes_seen = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int hang_count = 0;

    clipped_alpha_pixel_write DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .src_color     (src_color),
        .dest_color    (dest_color),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_enable  (write_enable),
        .word_address  (word_address),
        .blended_color (blended_color)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Source-over with exact rounded division by 255 per channel.
    function automatic logic [capw_pkg::COLOR_W-1:0] blend_over(
        logic [capw_pkg::COLOR_W-1:0] src,
        logic [capw_pkg::COLOR_W-1:0] dst);
        int a;
        logic [capw_pkg::COLOR_W-1:0] mixed;
        a = int'(src[31:24]);
        if (src[31:24] == capw_pkg::ALPHA_OPAQUE)
            return src;
        if (src[31:24] == capw_pkg::ALPHA_CLEAR)
            return dst;
        for (int ch = 0; ch < 3; ch++)
            mixed[8*ch +: 8] = 8'((int'(src[8*ch +: 8]) * a
                                   + int'(dst[8*ch +: 8]) * (255 - a) + 127) / 255);
        // Output alpha keeps the source alpha and adds what shows through.
        mixed[31:24] = 8'(a + (int'(dst[31:24]) * (255 - a) + 127) / 255);
        return mixed;
    endfunction

    function automatic int saturate_canvas(logic [capw_pkg::CLIP_W-1:0] side);
        return (int'(side) > capw_pkg::CANVAS_MAX) ? capw_pkg::CANVAS_MAX : int'(side);
    endfunction

    function automatic pixel_write_t predict_pixel(pixel_word_t w);
        int x;
        int y;
        longint addr;
        pixel_write_t res;
        x = int'($signed(w.pos_x));
        y = int'($signed(w.pos_y));
        if (x >= int'(clip_left_r) && x < int'(clip_right_r) &&
            y >= int'(clip_top_r) && y < int'(clip_bottom_r) &&
            x >= 0 && x < saturate_canvas(canvas_w_r) &&
            y >= 0 && y < saturate_canvas(canvas_h_r))
        begin
            // Full-width product, then wrap to the address bus.
            addr = longint'(y) * longint'(row_stride_r) + longint'(x);
            res.enable  = 1'b1;
            res.address = addr[capw_pkg::ADDR_W-1:0];
            res.color   = blend_over(w.src, w.dest);
        end
        else
        begin
            // Rejected pixels pass the frame buffer value through, address 0.
            res.enable  = 1'b0;
            res.address = '0;
            res.color   = w.dest;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers queued pixels, idles now and then
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // Predict at acceptance, with the settings in force right now.
            if (in_valid && !in_stall)
                expected_writes.push_back(predict_pixel(offered));
            // A stalled word is held; otherwise load the next or go idle.
            if (!in_valid || !in_stall)
            begin
                if (pending_pixels.size() > 0 &&
                    (no_idling || $urandom_range(99) >= 6))
                begin
                    offered = pending_pixels.pop_front();
                    pos_x      <= offered.pos_x;
                    pos_y      <= offered.pos_y;
                    src_color  <= offered.src;
                    dest_color <= offered.dest;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: checks each word, drives out_stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_write_t want;
        if (out_valid && !out_stall)
        begin
            writes_seen++;
            if (expected_writes.size() == 0)
            begin
                $error("output word with none expected: we=%0d addr=%h color=%h",
                       write_enable, word_address, blended_color);
                fail_count++;
            end
            else
            begin
                want = expected_writes.pop_front();
                if (write_enable !== want.enable)
                begin
                    $error("write_enable: expected %0d, got %0d",
                           want.enable, write_enable);
                    fail_count++;
                end
                if (word_address !== want.address)
                begin
                    $error("word_address: expected %h, got %h",
                           want.address, word_address);
                    fail_count++;
                end
                if (blended_color !== want.color)
                begin
                    $error("blended_color: expected %h, got %h",
                           want.color, blended_color);
                    fail_count++;
                end
            end
        end

        // One long hold-off fills the pipe so in_stall has to rise while
        // the driver still has words to offer.
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && writes_seen >= HOLD_AT_WORD)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !no_idling && ($urandom_range(99) < 6);
        end
    end

    // Hang detector: no handshake on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                hang_count <= 0;
            end
            else if (hang_count >= HANG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                hang_count <= hang_count + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic write_register(input logic [capw_pkg::CFG_IDX_W-1:0] idx,
                                  input int value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= capw_pkg::CFG_DATA_W'(value);
        case (idx)
            capw_pkg::REG_CLIP_LEFT:     clip_left_r   = capw_pkg::CLIP_W'(value);
            capw_pkg::REG_CLIP_TOP:      clip_top_r    = capw_pkg::CLIP_W'(value);
            capw_pkg::REG_CLIP_RIGHT:    clip_right_r  = capw_pkg::CLIP_W'(value);
            capw_pkg::REG_CLIP_BOTTOM:   clip_bottom_r = capw_pkg::CLIP_W'(value);
            capw_pkg::REG_CANVAS_WIDTH:  canvas_w_r    = capw_pkg::CLIP_W'(value);
            capw_pkg::REG_CANVAS_HEIGHT: canvas_h_r    = capw_pkg::CLIP_W'(value);
            capw_pkg::REG_ROW_STRIDE:    row_stride_r  = capw_pkg::STRIDE_W'(value);
            default:                     ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_setting(input int left, input int top, input int right,
                                 input int bottom, input int width, input int height,
                                 input int stride);
        write_register(capw_pkg::REG_CLIP_LEFT, left);
        write_register(capw_pkg::REG_CLIP_TOP, top);
        write_register(capw_pkg::REG_CLIP_RIGHT, right);
        write_register(capw_pkg::REG_CLIP_BOTTOM, bottom);
        write_register(capw_pkg::REG_CANVAS_WIDTH, width);
        write_register(capw_pkg::REG_CANVAS_HEIGHT, height);
        write_register(capw_pkg::REG_ROW_STRIDE, stride);
    endtask

    // Sender holds back until every word has come out and the pipe is empty.
    task automatic drain;
        while (pending_pixels.size() > 0 || in_valid || expected_writes.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic queue_pixel(input int x, input int y,
                               input logic [capw_pkg::COLOR_W-1:0] src,
                               input logic [capw_pkg::COLOR_W-1:0] dst);
        pixel_word_t w;
        w.pos_x = capw_pkg::POS_W'(x);
        w.pos_y = capw_pkg::POS_W'(y);
        w.src   = src;
        w.dest  = dst;
        pending_pixels.push_back(w);
    endtask

    // Coordinate: wild 16-bit values, values hugging an edge, or in-window.
    function automatic int pick_coord(int first, int past, int canvas);
        int hi;
        int e;
        int r;
        hi = (past < canvas) ? past : canvas;
        r  = $urandom_range(99);
        if (r < 15)
            return int'($signed(capw_pkg::POS_W'($urandom)));
        if (r < 45)
        begin
            case ($urandom_range(3))
                0:       e = first;
                1:       e = past;
                2:       e = canvas;
                default: e = 0;
            endcase
            return e + int'($urandom_range(4)) - 2;
        end
        if (hi > first)
            return int'($urandom_range(hi - 1, first));
        return int'($urandom_range(4200));
    endfunction

    // Source alpha leans on the opaque and clear shortcuts.
    function automatic logic [capw_pkg::COLOR_W-1:0] pick_source();
        logic [capw_pkg::COLOR_W-1:0] c;
        int r;
        c = $urandom;
        r = $urandom_range(99);
        if (r < 15)
            c[31:24] = capw_pkg::ALPHA_CLEAR;
        else if (r < 30)
            c[31:24] = capw_pkg::ALPHA_OPAQUE;
        return c;
    endfunction

    task automatic queue_random(input int count);
        repeat (count)
            queue_pixel(pick_coord(int'(clip_left_r), int'(clip_right_r),
                                   saturate_canvas(canvas_w_r)),
                        pick_coord(int'(clip_top_r), int'(clip_bottom_r),
                                   saturate_canvas(canvas_h_r)),
                        pick_source(), $urandom);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: blend shortcuts, rounding, canvas edges, wild coords.
        queue_pixel(0, 0, 32'hFF123456, 32'h11223344);
        queue_pixel(4095, 4095, 32'h00ABCDEF, 32'h8899AABB);
        queue_pixel(4096, 5, 32'h80FFFFFF, 32'h00000000);
        queue_pixel(5, 4096, 32'h80FFFFFF, 32'h00000000);
        queue_pixel(-1, 0, 32'h40102030, 32'hC0405060);
        queue_pixel(0, -1, 32'h40102030, 32'hC0405060);
        queue_pixel(-32768, -32768, 32'h7F7F7F7F, 32'hFFFFFFFF);
        queue_pixel(32767, 32767, 32'h7F7F7F7F, 32'hFFFFFFFF);
        queue_pixel(100, 200, 32'h80FF00FF, 32'h4000FF00);
        queue_pixel(17, 33, 32'h01FFFFFF, 32'h00000000);
        queue_pixel(4094, 1, 32'hFEFFFFFF, 32'hFF000000);
        queue_pixel(1, 4094, 32'h7F808080, 32'hFF7F7F7F);
        queue_pixel(1, 1, 32'hFFFFFFFF, 32'h00000000);
        queue_pixel(2, 2, 32'h00000000, 32'hFFFFFFFF);
        // The long output hold-off lands in this batch.
        queue_random(300);
        drain;

        // Small window; clip bottom reaches past the canvas.
        apply_setting(2, 3, 10, 9, 12, 8, 16);
        queue_pixel(2, 3, 32'hC0A0B0C0, 32'h20304050);
        queue_pixel(9, 7, 32'h3F010203, 32'hFFFEFDFC);
        queue_pixel(10, 3, 32'hC0A0B0C0, 32'h20304050);
        queue_pixel(1, 3, 32'hC0A0B0C0, 32'h20304050);
        queue_pixel(2, 8, 32'hC0A0B0C0, 32'h20304050);
        queue_random(150);
        drain;

        // Registers at full width: canvas saturates, address wraps.
        apply_setting(0, 0, 8191, 8191, 8191, 8191, 16383);
        queue_pixel(4095, 4095, 32'h9955AA33, 32'h66CC1188);
        queue_pixel(4096, 0, 32'h9955AA33, 32'h66CC1188);
        queue_pixel(0, 4096, 32'h9955AA33, 32'h66CC1188);
        queue_random(200);
        drain;

        // Inverted clip on both axes: nothing may be written.
        apply_setting(100, 50, 50, 10, 4096, 4096, 4096);
        queue_pixel(75, 20, 32'hFF000000, 32'h12345678);
        queue_random(60);
        drain;

        // Zero canvas.
        apply_setting(0, 0, 4096, 4096, 0, 0, 8192);
        queue_pixel(0, 0, 32'hFF000000, 32'h12345678);
        queue_random(40);
        drain;

        // Single-pixel canvas, unit stride.
        apply_setting(0, 0, 1, 1, 1, 1, 1);
        queue_pixel(0, 0, 32'h5A5A5A5A, 32'hA5A5A5A5);
        queue_pixel(1, 0, 32'h5A5A5A5A, 32'hA5A5A5A5);
        queue_pixel(0, 1, 32'h5A5A5A5A, 32'hA5A5A5A5);
        queue_random(60);
        drain;

        // Random settings; the first batch runs back to back with no idling.
        for (int phase = 0; phase < 4; phase++)
        begin
            no_idling = (phase == 0);
            apply_setting($urandom_range(2000), $urandom_range(2000),
                          $urandom_range(8191), $urandom_range(8191),
                          $urandom_range(8191), $urandom_range(8191),
                          $urandom_range(16383));
            queue_random(150);
            drain;
        end
        no_idling = 1'b0;

        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
